// ===== hw/rtl/slave_clock_impulse_controller_top_defines.svh =====
// Assertion macros for the slave clock impulse controller.
`ifndef SLAVE_CLOCK_IMPULSE_CONTROLLER_TOP_DEFINES_SVH
`define SLAVE_CLOCK_IMPULSE_CONTROLLER_TOP_DEFINES_SVH

// Condition must hold in the same cycle as its trigger.
`define SCIC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Condition must hold in the cycle after its trigger.
`define SCIC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/scic_pkg.sv =====
// Types and constants of the slave clock impulse controller.
`timescale 1ns / 1ps

package scic_pkg;

  // Impulse queue width and its saturation value
  localparam int unsigned QUEUE_BITS = 16;
  localparam longint unsigned QUEUE_MAX = (64'd1 << QUEUE_BITS) - 64'd1;
  localparam logic [QUEUE_BITS-1:0] QUEUE_TOP = QUEUE_BITS'(QUEUE_MAX);

  // Time constants
  localparam int unsigned SEC_PER_MIN  = 60;
  localparam int unsigned SEC_LAST     = 59;
  localparam int unsigned MIN_PER_HOUR = 60;
  localparam int unsigned MIN_PER_DAY  = 60 * 24;

  // Queue remainder modulo one day of minutes, tracked alongside the queue
  localparam int unsigned REM_W = 11;
  localparam logic [REM_W-1:0] SAT_REM = REM_W'(QUEUE_MAX % 64'(MIN_PER_DAY));

  // Register reset values
  localparam logic [4:0] KEY_DEB_RST     = 5'd20;
  localparam logic [5:0] SUPPLY_DEB_RST  = 6'd10;
  localparam logic [7:0] EXEC_PERIOD_RST = 8'd100;

  // Key bit positions
  localparam int unsigned KEY_HOUR_BIT   = 0;
  localparam int unsigned KEY_MINUTE_BIT = 1;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_KEY_DEB     = 2'd0,
    CFG_SUPPLY_DEB  = 2'd1,
    CFG_EXEC_PERIOD = 2'd2
  } cfg_idx_e;

  // Input transaction function codes
  typedef enum logic [1:0] {
    FUNC_TICK    = 2'd0,
    FUNC_WAKE    = 2'd1,
    FUNC_RESTORE = 2'd2
  } func_e;

  typedef struct packed {
    logic [1:0] func;
    logic       key_hour;
    logic       key_minute;
    logic       mains_present;
    logic       second_pulse;
    logic [5:0] remaining_alarm;
  } scic_in_t;

  typedef struct packed {
    logic        fire_impulse;
    logic        coil_polarity;
    logic        hold_drive_supply;
    logic        blink_second;
    logic        battery_entered;
    logic [5:0]  wake_delay;
    logic        battery_mode;
    logic [15:0] pending_impulses;
    logic [5:0]  seconds_count;
  } scic_out_t;

  // Queue with its remainder modulo a day
  typedef struct packed {
    logic [QUEUE_BITS-1:0] q;
    logic [REM_W-1:0]      r;
  } scic_cnt_t;

endpackage

// ===== hw/rtl/slave_clock_impulse_controller_top.sv =====
// Slave clock impulse controller: key debounce, step pacing, impulse queue.
//
//  channel  direction  handshake                 payload
//  in       input      in_valid_i / in_ready_o   in_data_i   (scic_in_t)
//  out      output     out_valid_o / out_ready_i out_data_o  (scic_out_t)
//  cfg      input      cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// One transaction per cycle while in_ready_o; result enters the output register
// on the next cycle. All state updates in the single cycle of acceptance.
// Input is taken while the output register is empty or being emptied, so a
// stalled output holds one result and blocks the input only while it waits.
// Reset restores register defaults and clears all counters and the queue.
`timescale 1ns / 1ps

`include "slave_clock_impulse_controller_top_defines.svh"

module slave_clock_impulse_controller_top
  import scic_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  scic_in_t   in_data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output scic_out_t  out_data_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_index_i,
  input  logic [7:0] cfg_data_i
);

  // Saturating add to the queue, remainder kept in step
  function automatic scic_cnt_t cnt_add(scic_cnt_t c, logic [5:0] n);
    logic [QUEUE_BITS:0] s;
    logic [REM_W:0]      r;
    scic_cnt_t           res;
    s = {1'b0, c.q} + (QUEUE_BITS+1)'(n);
    r = {1'b0, c.r} + (REM_W+1)'(n);
    if (r >= (REM_W+1)'(MIN_PER_DAY)) begin
      r = r - (REM_W+1)'(MIN_PER_DAY);
    end
    if (s > {1'b0, QUEUE_TOP}) begin
      res.q = QUEUE_TOP;
      res.r = SAT_REM;
    end else begin
      res.q = s[QUEUE_BITS-1:0];
      res.r = r[REM_W-1:0];
    end
    return res;
  endfunction

  // Decrement of a non-empty queue
  function automatic scic_cnt_t cnt_dec(scic_cnt_t c);
    scic_cnt_t res;
    res.q = c.q - QUEUE_BITS'(1);
    res.r = (c.r == '0) ? REM_W'(MIN_PER_DAY - 1) : c.r - REM_W'(1);
    return res;
  endfunction

  logic       in_fire;
  logic [4:0] cfg_kdeb_q;
  logic [5:0] cfg_sdeb_q;
  logic [7:0] cfg_period_q;

  logic [1:0] last_keys_q, last_keys_d;
  logic [4:0] kstab_q, kstab_d;
  logic [1:0] acc_keys_q, acc_keys_d;
  logic [7:0] exec_cnt_q, exec_cnt_d;
  logic       exec_pend_q, exec_pend_d;
  logic [5:0] mloss_q, mloss_d;
  logic       batt_q, batt_d;
  logic [5:0] sec_q, sec_d;
  logic       sec_latch_q, sec_latch_d;
  scic_cnt_t  cnt_q, cnt_d;
  logic       anchor_q, anchor_d;

  logic       out_valid_q;
  scic_out_t  out_data_q;
  scic_out_t  res;

  // Step temporaries
  logic [1:0] keys;
  logic [5:0] kc;
  logic [7:0] ec;
  logic       pend;
  logic [6:0] mc;
  logic       go;
  logic [5:0] sc;
  scic_cnt_t  cnt_a;

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_fire     = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_kdeb_q   <= KEY_DEB_RST;
      cfg_sdeb_q   <= SUPPLY_DEB_RST;
      cfg_period_q <= EXEC_PERIOD_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_KEY_DEB:     cfg_kdeb_q   <= cfg_data_i[4:0];
        CFG_SUPPLY_DEB:  cfg_sdeb_q   <= cfg_data_i[5:0];
        CFG_EXEC_PERIOD: cfg_period_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Next state and result for one transaction
  always_comb begin
    last_keys_d = last_keys_q;
    kstab_d     = kstab_q;
    acc_keys_d  = acc_keys_q;
    exec_cnt_d  = exec_cnt_q;
    exec_pend_d = exec_pend_q;
    mloss_d     = mloss_q;
    batt_d      = batt_q;
    sec_d       = sec_q;
    sec_latch_d = sec_latch_q;
    cnt_d       = cnt_q;
    anchor_d    = anchor_q;
    res         = '0;
    keys        = {in_data_i.key_minute, in_data_i.key_hour};
    kc          = '0;
    ec          = '0;
    pend        = 1'b0;
    mc          = '0;
    go          = 1'b1;
    sc          = '0;
    cnt_a       = cnt_q;

    if (in_fire) begin
      sec_latch_d = sec_latch_q | in_data_i.second_pulse;
      unique case (in_data_i.func)
        FUNC_TICK: begin
          if (!batt_q) begin
            // key debounce
            if (keys == last_keys_q) begin
              kc = {1'b0, kstab_q} + 6'd1;
              if (kc > {1'b0, cfg_kdeb_q}) begin
                kc         = {1'b0, cfg_kdeb_q};
                acc_keys_d = keys;
              end
              kstab_d = kc[4:0];
            end else begin
              kstab_d = '0;
            end
            last_keys_d = keys;

            // step pacing
            ec   = exec_cnt_q + 8'd1;
            pend = exec_pend_q;
            if (ec >= cfg_period_q) begin
              ec   = '0;
              pend = 1'b1;
            end
            exec_cnt_d  = ec;
            exec_pend_d = 1'b0;

            if (pend) begin
              // mains loss debounce
              if (!in_data_i.mains_present) begin
                mc = {1'b0, mloss_q} + 7'd1;
                if (mc > {1'b0, cfg_sdeb_q}) begin
                  mloss_d             = '0;
                  batt_d              = 1'b1;
                  res.battery_entered = 1'b1;
                  res.wake_delay      = 6'(SEC_PER_MIN) - sec_q;
                  go                  = 1'b0;
                end else begin
                  mloss_d = mc[5:0];
                end
              end else begin
                mloss_d = '0;
              end

              if (go) begin
                // fire a queued impulse, else add from the keys
                if (cnt_q.q != '0 && mloss_d == '0) begin
                  cnt_a                 = cnt_dec(cnt_q);
                  res.fire_impulse      = 1'b1;
                  res.coil_polarity     = anchor_q;
                  anchor_d              = ~anchor_q;
                  res.hold_drive_supply = (cnt_a.q != '0);
                end else if (acc_keys_d[KEY_MINUTE_BIT]) begin
                  cnt_a = cnt_add(cnt_q, 6'd1);
                end else if (acc_keys_d[KEY_HOUR_BIT]) begin
                  cnt_a = cnt_add(cnt_q, 6'(MIN_PER_HOUR));
                end

                // second counting, a full minute queues an impulse
                if (sec_latch_d) begin
                  sec_latch_d      = 1'b0;
                  res.blink_second = 1'b1;
                  sc               = sec_q + 6'd1;
                  if (sc >= 6'(SEC_PER_MIN)) begin
                    sc    = '0;
                    cnt_a = cnt_add(cnt_a, 6'd1);
                  end
                  sec_d = sc;
                end
                cnt_d = cnt_a;
              end
            end
          end
        end
        FUNC_WAKE: begin
          if (batt_q) begin
            cnt_d = cnt_add(cnt_q, 6'd1);
          end
        end
        FUNC_RESTORE: begin
          if (batt_q) begin
            sec_d = (in_data_i.remaining_alarm > 6'(SEC_LAST)) ? '0 :
                    6'(SEC_LAST) - in_data_i.remaining_alarm;
            batt_d  = 1'b0;
            cnt_a.q = QUEUE_BITS'(cnt_q.r);
            cnt_a.r = cnt_q.r;
            cnt_d   = cnt_add(cnt_a, 6'd1);
          end
        end
        default: ;
      endcase
    end

    res.battery_mode     = batt_d;
    res.pending_impulses = 16'(cnt_d.q);
    res.seconds_count    = sec_d;
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_keys_q <= '0;
      kstab_q     <= '0;
      acc_keys_q  <= '0;
      exec_cnt_q  <= '0;
      exec_pend_q <= 1'b1;
      mloss_q     <= '0;
      batt_q      <= 1'b0;
      sec_q       <= '0;
      sec_latch_q <= 1'b0;
      cnt_q       <= '0;
      anchor_q    <= 1'b0;
    end else begin
      last_keys_q <= last_keys_d;
      kstab_q     <= kstab_d;
      acc_keys_q  <= acc_keys_d;
      exec_cnt_q  <= exec_cnt_d;
      exec_pend_q <= exec_pend_d;
      mloss_q     <= mloss_d;
      batt_q      <= batt_d;
      sec_q       <= sec_d;
      sec_latch_q <= sec_latch_d;
      cnt_q       <= cnt_d;
      anchor_q    <= anchor_d;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_data_q <= res;
    end
  end

  // Checks
  `SCIC_ASSERT_NOW(a_rem_range, 1'b1, cnt_q.r < REM_W'(MIN_PER_DAY), "queue remainder out of range")
  `SCIC_ASSERT_NOW(a_sec_range, 1'b1, sec_q < 6'(SEC_PER_MIN), "second counter out of range")
  `SCIC_ASSERT_NEXT(a_result_follows, in_fire, out_valid_o, "accepted transaction left no result")
  `SCIC_ASSERT_NOW(a_entry_result, out_valid_o && out_data_o.battery_entered, out_data_o.battery_mode && out_data_o.wake_delay != '0 && !out_data_o.fire_impulse, "battery entry result inconsistent")

endmodule

// ===== tb/sv/scic_tb_pkg.sv =====
// Scoreboard class for the slave clock impulse controller testbench.
`timescale 1ns / 1ps

package scic_tb_pkg;
  import scic_pkg::*;

  // Upper bound on reported mismatches, keeps the log readable on a bad build
  localparam int unsigned MAX_REPORTS = 100;

  class impulse_scoreboard;
    // Register copies
    logic [4:0] cfg_key_deb;
    logic [5:0] cfg_supply_deb;
    logic [7:0] cfg_exec_period;

    // Clock controller state as seen from outside
    logic [1:0]            keys_prev;
    logic [4:0]            keys_stable_ticks;
    logic [1:0]            keys_taken;
    logic [7:0]            tick_count;
    logic                  step_due;
    logic [5:0]            loss_steps;
    logic                  on_battery;
    logic [5:0]            sec_now;
    logic                  sec_flag;
    logic [QUEUE_BITS-1:0] queue_len;
    logic                  next_polarity;

    // Results still owed by the block, oldest first
    scic_out_t   awaited_results[$];
    int unsigned live_items;
    int unsigned failures;

    function new();
      cfg_key_deb       = KEY_DEB_RST;
      cfg_supply_deb    = SUPPLY_DEB_RST;
      cfg_exec_period   = EXEC_PERIOD_RST;
      keys_prev         = '0;
      keys_stable_ticks = '0;
      keys_taken        = '0;
      tick_count        = '0;
      step_due          = 1'b1;
      loss_steps        = '0;
      on_battery        = 1'b0;
      sec_now           = '0;
      sec_flag          = 1'b0;
      queue_len         = '0;
      next_polarity     = 1'b0;
      live_items        = 0;
      failures          = 0;
    endfunction

    function void set_register(cfg_idx_e idx, logic [7:0] value);
      case (idx)
        CFG_KEY_DEB:     cfg_key_deb = value[4:0];
        CFG_SUPPLY_DEB:  cfg_supply_deb = value[5:0];
        CFG_EXEC_PERIOD: cfg_exec_period = value;
        default: ;
      endcase
    endfunction

    function int unsigned awaiting();
      return awaited_results.size();
    endfunction

    // Saturating add to the impulse queue
    function void grow_queue(int unsigned n);
      longint unsigned total;
      total = queue_len;
      total += n;
      if (total > QUEUE_MAX) queue_len = QUEUE_TOP;
      else queue_len = QUEUE_BITS'(total);
    endfunction

    // One transaction through the controller, returns the result it produces
    function scic_out_t predict_step(scic_in_t x);
      scic_out_t  r;
      logic [1:0] keys;
      logic [5:0] key_next;
      logic [6:0] loss_next;
      logic       proceed;
      r = '0;
      keys = '0;
      keys[KEY_HOUR_BIT] = x.key_hour;
      keys[KEY_MINUTE_BIT] = x.key_minute;
      // second event is latched whatever the function
      if (x.second_pulse) sec_flag = 1'b1;

      if (x.func == FUNC_TICK && !on_battery) begin
        // key debounce, counter one bit wider then clamped
        if (keys == keys_prev) begin
          key_next = {1'b0, keys_stable_ticks} + 6'd1;
          if (key_next > {1'b0, cfg_key_deb}) begin
            key_next = {1'b0, cfg_key_deb};
            keys_taken = keys;
          end
          keys_stable_ticks = key_next[4:0];
        end else begin
          keys_stable_ticks = '0;
        end
        keys_prev = keys;

        // step pacing
        tick_count = tick_count + 8'd1;
        if (tick_count >= cfg_exec_period) begin
          tick_count = '0;
          step_due = 1'b1;
        end

        if (step_due) begin
          step_due = 1'b0;
          proceed = 1'b1;
          // mains loss debounce
          if (!x.mains_present) begin
            loss_next = {1'b0, loss_steps} + 7'd1;
            if (loss_next > {1'b0, cfg_supply_deb}) begin
              loss_steps = '0;
              on_battery = 1'b1;
              r.battery_entered = 1'b1;
              r.wake_delay = 6'(SEC_PER_MIN - sec_now);
              proceed = 1'b0;
            end else begin
              loss_steps = loss_next[5:0];
            end
          end else begin
            loss_steps = '0;
          end

          if (proceed) begin
            // fire a queued impulse, else take minutes from the keys
            if (queue_len != 0 && loss_steps == 0) begin
              queue_len = queue_len - 1'b1;
              r.fire_impulse = 1'b1;
              r.coil_polarity = next_polarity;
              next_polarity = ~next_polarity;
              r.hold_drive_supply = (queue_len != 0);
            end else if (keys_taken[KEY_MINUTE_BIT]) begin
              grow_queue(1);
            end else if (keys_taken[KEY_HOUR_BIT]) begin
              grow_queue(MIN_PER_HOUR);
            end

            if (sec_flag) begin
              sec_flag = 1'b0;
              r.blink_second = 1'b1;
              sec_now = sec_now + 6'd1;
              if (sec_now >= SEC_PER_MIN) begin
                sec_now = '0;
                grow_queue(1);
              end
            end
          end
        end
      end else if (x.func == FUNC_WAKE && on_battery) begin
        grow_queue(1);
      end else if (x.func == FUNC_RESTORE && on_battery) begin
        // back on mains: reload seconds, fold the queue into one day
        if (x.remaining_alarm > SEC_LAST) sec_now = '0;
        else sec_now = 6'(SEC_LAST - x.remaining_alarm);
        on_battery = 1'b0;
        queue_len = QUEUE_BITS'(queue_len % MIN_PER_DAY);
        grow_queue(1);
      end

      r.battery_mode = on_battery;
      r.pending_impulses = 16'(queue_len);
      r.seconds_count = sec_now;
      return r;
    endfunction

    // Accepted input transaction: work out and store its result
    function void note_accepted(scic_in_t x);
      live_items++;
      awaited_results.push_back(predict_step(x));
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        failures++;
        if (failures <= MAX_REPORTS)
          $error("%s: expected %0d, got %0d", name, want, got);
      end
    endfunction

    // Accepted output transaction against the oldest expectation
    function void check_result(scic_out_t got);
      scic_out_t want;
      if (awaited_results.size() == 0) begin
        failures++;
        if (failures <= MAX_REPORTS) $error("result transaction with none outstanding");
        return;
      end
      want = awaited_results.pop_front();
      compare_field("fire_impulse", want.fire_impulse, got.fire_impulse);
      compare_field("coil_polarity", want.coil_polarity, got.coil_polarity);
      compare_field("hold_drive_supply", want.hold_drive_supply, got.hold_drive_supply);
      compare_field("blink_second", want.blink_second, got.blink_second);
      compare_field("battery_entered", want.battery_entered, got.battery_entered);
      compare_field("wake_delay", want.wake_delay, got.wake_delay);
      compare_field("battery_mode", want.battery_mode, got.battery_mode);
      compare_field("pending_impulses", want.pending_impulses, got.pending_impulses);
      compare_field("seconds_count", want.seconds_count, got.seconds_count);
    endfunction
  endclass

endpackage

// ===== tb/sv/slave_clock_impulse_controller_top_tb.sv =====
// Top-level testbench of the slave clock impulse controller.
`timescale 1ns / 1ps

module slave_clock_impulse_controller_top_tb;
  import scic_pkg::*;
  import scic_tb_pkg::*;

  localparam int unsigned CLK_PERIOD    = 8;
  localparam int unsigned RESET_CYCLES  = 8;
  localparam int unsigned CYCLE_LIMIT   = 1_000_000;
  localparam int unsigned RANDOM_ITEMS  = 900;
  localparam int unsigned PHASES        = 8;
  localparam int unsigned LONG_HOLD     = 200;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam logic [1:0]  FUNC_UNUSED   = 2'd3;

  // Key patterns: bit 0 hour, bit 1 minute
  localparam logic [1:0] KEYS_NONE   = 2'b00;
  localparam logic [1:0] KEYS_HOUR   = 2'b01;
  localparam logic [1:0] KEYS_MINUTE = 2'b10;
  localparam logic [1:0] KEYS_BOTH   = 2'b11;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_ready_o;
  scic_in_t   in_data_i;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  scic_out_t  out_data_o;
  logic       cfg_valid_i;
  logic       cfg_ready_o;
  logic [1:0] cfg_index_i;
  logic [7:0] cfg_data_i;

  impulse_scoreboard board = new();
  int unsigned       cycle_count = 0;
  int unsigned       ready_gap;
  logic              no_gaps = 1'b0;
  logic              long_hold_req = 1'b0;

  slave_clock_impulse_controller_top DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // Clock
  always begin
    #(CLK_PERIOD / 2) clk_i = 1'b1;
    #(CLK_PERIOD / 2) clk_i = 1'b0;
  end

  // Run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 15);
    return $urandom_range(16, 60);
  endfunction

  // Receiver: random back-pressure, or a long hold-off on request
  always begin
    @(negedge clk_i);
    if (long_hold_req) begin
      out_ready_i <= 1'b0;
      repeat (LONG_HOLD - 1) @(negedge clk_i);
      long_hold_req = 1'b0;
    end else begin
      ready_gap = no_gaps ? 0 : pick_gap();
      out_ready_i <= (ready_gap == 0);
      if (ready_gap > 1) repeat (ready_gap - 1) @(negedge clk_i);
    end
  end

  // Result monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) board.check_result(out_data_o);
  end

  function automatic scic_in_t make_item(logic [1:0] func, logic [1:0] keys, logic mains,
                                         logic sec, logic [5:0] remain);
    scic_in_t item;
    item.func            = func;
    item.key_hour        = keys[KEY_HOUR_BIT];
    item.key_minute      = keys[KEY_MINUTE_BIT];
    item.mains_present   = mains;
    item.second_pulse    = sec;
    item.remaining_alarm = remain;
    return item;
  endfunction

  // Alarm remainder, mostly in range, sometimes above 59
  function automatic logic [5:0] pick_alarm();
    if ($urandom_range(0, 4) == 0) return 6'($urandom_range(SEC_PER_MIN, 63));
    return 6'($urandom_range(0, SEC_LAST));
  endfunction

  function automatic scic_in_t random_item();
    return make_item(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                     6'($urandom_range(0, 63)));
  endfunction

  // Offer one input transaction, after an optional gap
  task automatic send_item(input scic_in_t item);
    int unsigned gap;
    gap = no_gaps ? 0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_accepted(item);
  endtask

  // Stop offering and let every owed result come back
  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (board.awaiting() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [7:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    board.set_register(idx, value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic configure(input int unsigned key_ticks, input int unsigned supply_steps,
                           input int unsigned period);
    write_reg(CFG_KEY_DEB, 8'(key_ticks));
    write_reg(CFG_SUPPLY_DEB, 8'(supply_steps));
    write_reg(CFG_EXEC_PERIOD, 8'(period));
  endtask

  task automatic leave_battery();
    if (board.on_battery)
      send_item(make_item(FUNC_RESTORE, 2'($urandom_range(0, 3)), 1'b1,
                          1'($urandom_range(0, 1)), pick_alarm()));
  endtask

  // Millisecond ticks with held keys, mains mostly present
  task automatic run_ticks(input int unsigned n);
    logic [1:0] keys;
    logic       mains;
    leave_battery();
    keys = 2'($urandom_range(0, 3));
    repeat (n) begin
      if ($urandom_range(0, 9) == 0) keys = 2'($urandom_range(0, 3));
      mains = ($urandom_range(0, 19) != 0);
      send_item(make_item(FUNC_TICK, keys, mains, 1'($urandom_range(0, 1)),
                          6'($urandom_range(0, 63))));
    end
  endtask

  // Mains loss long enough for battery mode where affordable, wakeups, then return
  task automatic run_outage();
    int unsigned budget;
    int unsigned i;
    int unsigned roll;
    logic [1:0]  keys;
    budget = (board.cfg_supply_deb + 2) * board.cfg_exec_period;
    if (budget > 120) budget = $urandom_range(5, 40);
    keys = 2'($urandom_range(0, 3));
    for (i = 0; i < budget && !board.on_battery; i++)
      send_item(make_item(FUNC_TICK, keys, 1'b0, 1'($urandom_range(0, 1)),
                          6'($urandom_range(0, 63))));
    if (board.on_battery) begin
      repeat ($urandom_range(0, 8)) begin
        roll = $urandom_range(0, 99);
        if (roll < 70)
          send_item(make_item(FUNC_WAKE, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                              1'($urandom_range(0, 1)), 6'($urandom_range(0, 63))));
        else if (roll < 85)
          send_item(make_item(FUNC_TICK, keys, 1'($urandom_range(0, 1)),
                              1'($urandom_range(0, 1)), 6'($urandom_range(0, 63))));
        else
          send_item(random_item());
      end
      // occasionally the return is left out
      if ($urandom_range(0, 9) != 0) leave_battery();
    end
  endtask

  // Stimulus
  initial begin
    int unsigned phase;
    int unsigned target;
    int unsigned roll;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_KEY_DEB;
    cfg_data_i  = '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset values: first tick runs a step; ignored functions in mains mode
    send_item(make_item(FUNC_TICK, KEYS_NONE, 1'b1, 1'b0, 6'd0));
    send_item(make_item(FUNC_WAKE, KEYS_BOTH, 1'b0, 1'b1, 6'd59));
    send_item(make_item(FUNC_RESTORE, KEYS_NONE, 1'b1, 1'b0, 6'd59));
    send_item(make_item(FUNC_UNUSED, KEYS_BOTH, 1'b1, 1'b1, 6'd63));
    wait_idle();

    // Fastest settings: key handling, impulses, battery entry and return
    configure(1, 1, 1);
    send_item(make_item(FUNC_TICK, KEYS_MINUTE, 1'b1, 1'b0, 6'd0));
    send_item(make_item(FUNC_TICK, KEYS_MINUTE, 1'b1, 1'b0, 6'd0));
    send_item(make_item(FUNC_TICK, KEYS_MINUTE, 1'b1, 1'b0, 6'd0));
    send_item(make_item(FUNC_TICK, KEYS_MINUTE, 1'b1, 1'b1, 6'd0));
    send_item(make_item(FUNC_TICK, KEYS_BOTH, 1'b1, 1'b0, 6'd0));
    send_item(make_item(FUNC_TICK, KEYS_BOTH, 1'b1, 1'b0, 6'd0));
    send_item(make_item(FUNC_TICK, KEYS_BOTH, 1'b1, 1'b0, 6'd0));
    send_item(make_item(FUNC_TICK, KEYS_HOUR, 1'b1, 1'b0, 6'd0));
    send_item(make_item(FUNC_TICK, KEYS_HOUR, 1'b1, 1'b0, 6'd0));
    send_item(make_item(FUNC_TICK, KEYS_HOUR, 1'b1, 1'b0, 6'd0));
    send_item(make_item(FUNC_TICK, KEYS_NONE, 1'b0, 1'b0, 6'd0));
    send_item(make_item(FUNC_TICK, KEYS_NONE, 1'b0, 1'b1, 6'd0));
    // in battery: tick and unused code ignored, wakeups queue minutes
    send_item(make_item(FUNC_TICK, KEYS_NONE, 1'b1, 1'b0, 6'd0));
    send_item(make_item(FUNC_WAKE, KEYS_NONE, 1'b1, 1'b1, 6'd0));
    send_item(make_item(FUNC_WAKE, KEYS_BOTH, 1'b0, 1'b0, 6'd63));
    send_item(make_item(FUNC_UNUSED, KEYS_BOTH, 1'b1, 1'b1, 6'd63));
    // alarm remainder above range, then zero
    send_item(make_item(FUNC_RESTORE, KEYS_NONE, 1'b1, 1'b0, 6'd63));
    send_item(make_item(FUNC_TICK, KEYS_NONE, 1'b0, 1'b0, 6'd0));
    send_item(make_item(FUNC_TICK, KEYS_NONE, 1'b0, 1'b0, 6'd0));
    send_item(make_item(FUNC_RESTORE, KEYS_NONE, 1'b1, 1'b0, 6'd0));
    // second 59 wraps and queues a minute
    send_item(make_item(FUNC_TICK, KEYS_NONE, 1'b1, 1'b1, 6'd59));

    // Random phases under varied settings
    for (phase = 0; phase < PHASES; phase++) begin
      wait_idle();
      case (phase)
        0: configure(1, 1, 1);
        1: configure(31, 63, 255);
        2: configure(31, 63, 1);
        3: configure(KEY_DEB_RST, SUPPLY_DEB_RST, 2);
        default: configure($urandom_range(1, 8), $urandom_range(1, 12), $urandom_range(1, 6));
      endcase
      target = board.live_items + RANDOM_ITEMS / PHASES;
      // receiver holds off while the sender keeps offering
      if (phase % 2 == 1) begin
        long_hold_req = 1'b1;
        no_gaps = 1'b1;
        run_ticks(30);
      end
      while (board.live_items < target) begin
        no_gaps = ($urandom_range(0, 4) == 0);
        roll = $urandom_range(0, 99);
        if (roll < 45) run_ticks($urandom_range(3, 40));
        else if (roll < 75) run_outage();
        else repeat ($urandom_range(1, 4)) send_item(random_item());
      end
    end

    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (board.failures == 0 && board.awaiting() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/scic_pkg.sv
hw/rtl/slave_clock_impulse_controller_top.sv
tb/sv/scic_tb_pkg.sv
tb/sv/slave_clock_impulse_controller_top_tb.sv
